// ===== hw/rtl/scpt_pkg.sv =====
// ----------------------------------------------------------------------------
// scpt_pkg: shared types and constants of the shape pair collision test
// Shape kind codes, internal widths and the per-stage payload structs.
// ----------------------------------------------------------------------------
package scpt_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;

  // Doubled-scale coordinates: 2*x + 2*w needs two bits above a coordinate
  localparam int WIDE_BITS  = COORD_BITS + 2;
  // Magnitude of a centre-to-point distance and of a radius sum
  localparam int MAG_BITS   = WIDE_BITS;
  // Squares and their sum
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  // Shape kinds
  localparam logic [1:0] KIND_NONE         = 2'd0;
  localparam logic [1:0] KIND_BOX          = 2'd1;
  localparam logic [1:0] KIND_BLOCK_CIRCLE = 2'd2;
  localparam logic [1:0] KIND_POINT_CIRCLE = 2'd3;

  // One shape at doubled scale
  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [WIDE_BITS-1:0] lo_x;
    logic signed [WIDE_BITS-1:0] hi_x;
    logic signed [WIDE_BITS-1:0] lo_y;
    logic signed [WIDE_BITS-1:0] hi_y;
    logic signed [WIDE_BITS-1:0] cx;
    logic signed [WIDE_BITS-1:0] cy;
    logic [COORD_BITS-1:0]       rad;
  } shape_t;

  // Circle centre, the point it is measured to, and the reach
  typedef struct packed {
    logic                        use_dist;
    logic                        fixed_hit;
    logic signed [WIDE_BITS-1:0] cx;
    logic signed [WIDE_BITS-1:0] cy;
    logic signed [WIDE_BITS-1:0] px;
    logic signed [WIDE_BITS-1:0] py;
    logic [MAG_BITS-1:0]         rr;
  } sel_t;

  // Distance magnitudes
  typedef struct packed {
    logic                use_dist;
    logic                fixed_hit;
    logic [MAG_BITS-1:0] mx;
    logic [MAG_BITS-1:0] my;
    logic [MAG_BITS-1:0] rr;
  } mag_t;

  // Squared terms
  typedef struct packed {
    logic               use_dist;
    logic               fixed_hit;
    logic [SQ_BITS-1:0] sx;
    logic [SQ_BITS-1:0] sy;
    logic [SQ_BITS-1:0] sr;
  } sq_t;

  function automatic logic is_circle(logic [1:0] kind);
    return (kind == KIND_BLOCK_CIRCLE) || (kind == KIND_POINT_CIRCLE);
  endfunction

endpackage

// ===== hw/rtl/scpt_shape_decode.sv =====
// ----------------------------------------------------------------------------
// scpt_shape_decode: raw shape fields to doubled-scale geometry
// Box bounds, circle centre and effective radius of one shape.
// ----------------------------------------------------------------------------
module scpt_shape_decode (
  input  logic [1:0]                           kind_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] y_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         width_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         height_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         radius_i,
  output scpt_pkg::shape_t                       shape_o
);
  import scpt_pkg::*;

  logic signed [WIDE_BITS-1:0] x2, y2;
  logic [SIZE_BITS-1:0]        big_side;

  // doubled position
  assign x2 = WIDE_BITS'($signed({x_i, 1'b0}));
  assign y2 = WIDE_BITS'($signed({y_i, 1'b0}));

  assign big_side = (width_i > height_i) ? width_i : height_i;

  always_comb begin
    shape_o.kind = kind_i;
    shape_o.lo_x = x2;
    shape_o.lo_y = y2;
    shape_o.hi_x = x2 + $signed(WIDE_BITS'({width_i, 1'b0}));
    shape_o.hi_y = y2 + $signed(WIDE_BITS'({height_i, 1'b0}));
    // zero radius: half the larger side, doubled
    shape_o.rad  = (radius_i != '0) ? {radius_i, 1'b0} : COORD_BITS'(big_side);
    // block circle sits at the block's middle
    if (kind_i == KIND_BLOCK_CIRCLE) begin
      shape_o.cx = x2 + $signed(WIDE_BITS'(width_i));
      shape_o.cy = y2 + $signed(WIDE_BITS'(height_i));
    end else begin
      shape_o.cx = x2;
      shape_o.cy = y2;
    end
  end

endmodule

// ===== hw/rtl/scpt_pair_select.sv =====
// ----------------------------------------------------------------------------
// scpt_pair_select: case split of a shape pair
// Picks circle/circle, circle/box or box/box, clamps for the mixed case,
// resolves the box/box test outright and reports no hit if either kind is none.
// ----------------------------------------------------------------------------
module scpt_pair_select (
  input  scpt_pkg::shape_t shape_a_i,
  input  scpt_pkg::shape_t shape_b_i,
  output scpt_pkg::sel_t   sel_o
);
  import scpt_pkg::*;

  function automatic logic signed [WIDE_BITS-1:0] clamp(
    logic signed [WIDE_BITS-1:0] v,
    logic signed [WIDE_BITS-1:0] lo,
    logic signed [WIDE_BITS-1:0] hi
  );
    logic signed [WIDE_BITS-1:0] r;
    r = (v > hi) ? hi : v;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

  logic   a_circ, b_circ, box_hit;
  shape_t circ, box;

  assign a_circ = is_circle(shape_a_i.kind);
  assign b_circ = is_circle(shape_b_i.kind);
  assign circ   = a_circ ? shape_a_i : shape_b_i;
  assign box    = a_circ ? shape_b_i : shape_a_i;

  // strict overlap: touching edges miss
  assign box_hit = (shape_a_i.lo_x < shape_b_i.hi_x) && (shape_a_i.hi_x > shape_b_i.lo_x) &&
                   (shape_a_i.lo_y < shape_b_i.hi_y) && (shape_a_i.hi_y > shape_b_i.lo_y);

  always_comb begin
    sel_o.use_dist  = 1'b0;
    sel_o.fixed_hit = 1'b0;
    sel_o.cx        = circ.cx;
    sel_o.cy        = circ.cy;
    sel_o.px        = circ.cx;
    sel_o.py        = circ.cy;
    sel_o.rr        = MAG_BITS'(circ.rad);
    if (shape_a_i.kind == KIND_NONE || shape_b_i.kind == KIND_NONE) begin
      sel_o.fixed_hit = 1'b0;
    end else if (a_circ && b_circ) begin
      sel_o.use_dist = 1'b1;
      sel_o.px       = shape_b_i.cx;
      sel_o.py       = shape_b_i.cy;
      sel_o.rr       = MAG_BITS'(shape_a_i.rad) + MAG_BITS'(shape_b_i.rad);
    end else if (a_circ || b_circ) begin
      // nearest point of the box to the circle centre
      sel_o.use_dist = 1'b1;
      sel_o.px       = clamp(circ.cx, box.lo_x, box.hi_x);
      sel_o.py       = clamp(circ.cy, box.lo_y, box.hi_y);
    end else begin
      sel_o.fixed_hit = box_hit;
    end
  end

endmodule

// ===== hw/rtl/shape_pair_collision_test.sv =====
// ----------------------------------------------------------------------------
// shape_pair_collision_test: overlap test for one pair of 2-D shapes
// Five-stage pipeline: decode, case select and clamp, distance magnitude,
// squaring, compare and output register.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns its
// hit flag through five register stages (decode, select/clamp, magnitude,
// squaring, compare into the output register); each stage holds its item
// while the next one is full, so a stall at the output backs up without
// losing or repeating anything.
module shape_pair_collision_test (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             a_kind_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] a_x_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] a_y_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         a_width_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         a_height_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         a_radius_i,
  input  logic [1:0]                             b_kind_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] b_x_i,
  input  logic signed [scpt_pkg::COORD_BITS-1:0] b_y_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         b_width_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         b_height_i,
  input  logic [scpt_pkg::SIZE_BITS-1:0]         b_radius_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   hit_o
);
  import scpt_pkg::*;

  // stage valids and stage readies
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  shape_t shape_a_d, shape_b_d, shape_a_q, shape_b_q;
  sel_t   s2_d, s2_q;
  mag_t   s3_d, s3_q;
  sq_t    s4_d, s4_q;
  logic   hit_d, hit_q;

  logic signed [WIDE_BITS:0] dx, dy;
  logic [WIDE_BITS:0]        ax, ay;
  logic [SUM_BITS-1:0]       dist_sum;

  // a stage takes new data when empty or when its content moves on
  assign s4_ready   = !out_valid_q || out_ready_i;
  assign s3_ready   = !s4_valid_q || s4_ready;
  assign s2_ready   = !s3_valid_q || s3_ready;
  assign s1_ready   = !s2_valid_q || s2_ready;
  assign in_ready_o = !s1_valid_q || s1_ready;

  // stage 1: decode both shapes
  scpt_shape_decode u_decode_a (
    .kind_i   (a_kind_i),
    .x_i      (a_x_i),
    .y_i      (a_y_i),
    .width_i  (a_width_i),
    .height_i (a_height_i),
    .radius_i (a_radius_i),
    .shape_o  (shape_a_d)
  );

  scpt_shape_decode u_decode_b (
    .kind_i   (b_kind_i),
    .x_i      (b_x_i),
    .y_i      (b_y_i),
    .width_i  (b_width_i),
    .height_i (b_height_i),
    .radius_i (b_radius_i),
    .shape_o  (shape_b_d)
  );

  // stage 2: case split and clamp
  scpt_pair_select u_select (
    .shape_a_i (shape_a_q),
    .shape_b_i (shape_b_q),
    .sel_o     (s2_d)
  );

  // stage 3: distance magnitudes
  assign dx = (WIDE_BITS+1)'(s2_q.cx) - (WIDE_BITS+1)'(s2_q.px);
  assign dy = (WIDE_BITS+1)'(s2_q.cy) - (WIDE_BITS+1)'(s2_q.py);
  assign ax = dx[WIDE_BITS] ? $unsigned(-dx) : $unsigned(dx);
  assign ay = dy[WIDE_BITS] ? $unsigned(-dy) : $unsigned(dy);

  always_comb begin
    s3_d.use_dist  = s2_q.use_dist;
    s3_d.fixed_hit = s2_q.fixed_hit;
    s3_d.mx        = ax[MAG_BITS-1:0];
    s3_d.my        = ay[MAG_BITS-1:0];
    s3_d.rr        = s2_q.rr;
  end

  // stage 4: squares
  always_comb begin
    s4_d.use_dist  = s3_q.use_dist;
    s4_d.fixed_hit = s3_q.fixed_hit;
    s4_d.sx        = SQ_BITS'(s3_q.mx) * SQ_BITS'(s3_q.mx);
    s4_d.sy        = SQ_BITS'(s3_q.my) * SQ_BITS'(s3_q.my);
    s4_d.sr        = SQ_BITS'(s3_q.rr) * SQ_BITS'(s3_q.rr);
  end

  // stage 5: compare
  assign dist_sum = SUM_BITS'(s4_q.sx) + SUM_BITS'(s4_q.sy);
  assign hit_d    = s4_q.use_dist ? (dist_sum <= SUM_BITS'(s4_q.sr)) : s4_q.fixed_hit;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q  <= in_valid_i;
      if (s1_ready)   s2_valid_q  <= s1_valid_q;
      if (s2_ready)   s3_valid_q  <= s2_valid_q;
      if (s3_ready)   s4_valid_q  <= s3_valid_q;
      if (s4_ready)   out_valid_q <= s4_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      shape_a_q <= shape_a_d;
      shape_b_q <= shape_b_d;
    end
    if (s1_ready && s1_valid_q) s2_q  <= s2_d;
    if (s2_ready && s2_valid_q) s3_q  <= s3_d;
    if (s3_ready && s3_valid_q) s4_q  <= s4_d;
    if (s4_ready && s4_valid_q) hit_q <= hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule
